### rtl/core/blsg_pkg.sv
`default_nettype none

package blsg_pkg;

   // microprogram counter
   localparam int UPC_W = 4;

   // input opcodes (tuser)
   localparam logic OPC_LOAD = 1'b0;
   localparam logic OPC_STEP = 1'b1;

   // row change per minor step
   localparam logic [1:0] ROW_NONE = 2'd0;
   localparam logic [1:0] ROW_DOWN = 2'd1;
   localparam logic [1:0] ROW_UP   = 2'd3;

   // wait field: what a step needs before it may fire
   localparam logic [1:0] WAIT_NONE = 2'd0;
   localparam logic [1:0] WAIT_REQ  = 2'd1;
   localparam logic [1:0] WAIT_OUT  = 2'd2;

   // datapath operations
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LATCH     = 4'd1;
   localparam logic [3:0] OP_SETUP     = 4'd2;
   localparam logic [3:0] OP_CLASS     = 4'd3;
   localparam logic [3:0] OP_AXIS_EMIT = 4'd4;
   localparam logic [3:0] OP_XM_INIT   = 4'd5;
   localparam logic [3:0] OP_XM_WALK   = 4'd6;
   localparam logic [3:0] OP_XM_EMIT   = 4'd7;
   localparam logic [3:0] OP_YM_EMIT   = 4'd8;

   // branch conditions
   localparam logic [2:0] COND_NEVER      = 3'd0;
   localparam logic [2:0] COND_ALWAYS     = 3'd1;
   localparam logic [2:0] COND_OPC_LOAD   = 3'd2;
   localparam logic [2:0] COND_NOT_ACTIVE = 3'd3;
   localparam logic [2:0] COND_AXIS       = 3'd4;
   localparam logic [2:0] COND_XMAJ       = 3'd5;
   localparam logic [2:0] COND_WALKING    = 3'd6;

   // microprogram addresses
   localparam logic [UPC_W-1:0] UA_IDLE     = 4'd0;
   localparam logic [UPC_W-1:0] UA_ACTIVE   = 4'd1;
   localparam logic [UPC_W-1:0] UA_KIND     = 4'd2;
   localparam logic [UPC_W-1:0] UA_MAJOR    = 4'd3;
   localparam logic [UPC_W-1:0] UA_YM_EMIT  = 4'd4;
   localparam logic [UPC_W-1:0] UA_XM_INIT  = 4'd5;
   localparam logic [UPC_W-1:0] UA_XM_WALK  = 4'd6;
   localparam logic [UPC_W-1:0] UA_XM_EMIT  = 4'd7;
   localparam logic [UPC_W-1:0] UA_AX_EMIT  = 4'd8;
   localparam logic [UPC_W-1:0] UA_LD_SETUP = 4'd9;
   localparam logic [UPC_W-1:0] UA_LD_CLASS = 4'd10;

   typedef struct packed {
      logic [1:0]       wait_kind;
      logic [3:0]       op;
      logic [2:0]       cond;
      logic [UPC_W-1:0] target;
   } ucode_word_type;

   function automatic ucode_word_type uword(input logic [1:0] w, input logic [3:0] o,
                                            input logic [2:0] c,
                                            input logic [UPC_W-1:0] t);
      ucode_word_type r;
      r.wait_kind = w;
      r.op        = o;
      r.cond      = c;
      r.target    = t;
      return r;
   endfunction

   // control store: one word per step, branch to target when cond holds
   function automatic ucode_word_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_word_type r;
      unique case (addr)
         UA_IDLE:     r = uword(WAIT_REQ,  OP_LATCH,     COND_OPC_LOAD,   UA_LD_SETUP);
         UA_ACTIVE:   r = uword(WAIT_NONE, OP_NONE,      COND_NOT_ACTIVE, UA_IDLE);
         UA_KIND:     r = uword(WAIT_NONE, OP_NONE,      COND_AXIS,       UA_AX_EMIT);
         UA_MAJOR:    r = uword(WAIT_NONE, OP_NONE,      COND_XMAJ,       UA_XM_INIT);
         UA_YM_EMIT:  r = uword(WAIT_OUT,  OP_YM_EMIT,   COND_ALWAYS,     UA_IDLE);
         UA_XM_INIT:  r = uword(WAIT_NONE, OP_XM_INIT,   COND_NEVER,      UA_IDLE);
         UA_XM_WALK:  r = uword(WAIT_NONE, OP_XM_WALK,   COND_WALKING,    UA_XM_WALK);
         UA_XM_EMIT:  r = uword(WAIT_OUT,  OP_XM_EMIT,   COND_ALWAYS,     UA_IDLE);
         UA_AX_EMIT:  r = uword(WAIT_OUT,  OP_AXIS_EMIT, COND_ALWAYS,     UA_IDLE);
         UA_LD_SETUP: r = uword(WAIT_NONE, OP_SETUP,     COND_NEVER,      UA_IDLE);
         UA_LD_CLASS: r = uword(WAIT_NONE, OP_CLASS,     COND_ALWAYS,     UA_IDLE);
         default:     r = uword(WAIT_NONE, OP_NONE,      COND_ALWAYS,     UA_IDLE);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/bresenham_line_span_generator.sv
`default_nettype none

// Line span generator: a load transfer (tuser = 0) takes two signed endpoints and
// prepares a line; each step transfer (tuser = 1) returns the next pixel run of
// that line, with tlast on the run that completes it. A step with no line
// loaded returns nothing. Horizontal and vertical lines come back as one
// rectangle, x-major lines as horizontal runs from the left endpoint, y-major
// lines as one pixel per row. A small microprogram drives the datapath one
// control word per cycle, holding a word that waits for a request or for a
// free output register. A load latches, sets up and classifies the line; an
// x-major run walks its error term one pixel per cycle before it is emitted.
// Results sit in an output register, so the next request is taken while a
// finished run still waits for the sink.
module bresenham_line_span_generator
   import blsg_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // start_x, start_y, end_x, end_y (lowest bits first), zero padded to bytes
   input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // opcode
   input  wire logic                 req_tuser,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // run_x, run_y, run_width, run_height (lowest bits first), zero padded to bytes
   output logic [((4*COORD_WIDTH+2+7)/8)*8-1:0] rsp_tdata,
   // last_run
   output logic                      rsp_tlast
);

   localparam int CW    = COORD_WIDTH;
   localparam int RSP_W = ((4*CW+2+7)/8)*8;
   localparam int PAD_W = RSP_W - (4*CW+2);

   // sequencer
   logic [UPC_W-1:0] upc_ff, upc_in;
   ucode_word_type   uw;
   logic             go;
   logic             cond_true;
   logic             out_free;

   // latched endpoints and differences
   logic [CW-1:0]        sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic signed [CW:0]   dx_ff, dx_in, dy_ff, dy_in;

   // line state
   logic          line_active_ff, line_active_in;
   logic          axis_aligned_ff, axis_aligned_in;
   logic          x_major_ff, x_major_in;
   logic [CW-1:0] cursor_x_ff, cursor_x_in, cursor_y_ff, cursor_y_in;
   logic [CW:0]   error_term_ff, error_term_in;
   logic [CW:0]   span_dx_ff, span_dx_in, span_dy_ff, span_dy_in;
   logic [1:0]    row_step_ff, row_step_in;
   logic [CW:0]   pixels_left_ff, pixels_left_in;
   logic [CW:0]   gap_ff, gap_in;
   logic [CW:0]   run_len_ff, run_len_in;
   logic          hit_ff, hit_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [CW:0]   rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;
   logic          rsp_last_ff, rsp_last_in;

   // shared datapath terms
   logic [CW-1:0] req_sx, req_sy, req_ex, req_ey;
   logic          err_ge_gap;
   logic [CW-1:0] cursor_y_adv;

   assign req_sx = req_tdata[0 +: CW];
   assign req_sy = req_tdata[CW +: CW];
   assign req_ex = req_tdata[2*CW +: CW];
   assign req_ey = req_tdata[3*CW +: CW];

   assign err_ge_gap = (error_term_ff >= gap_ff);

   // row advance by the stored direction
   always_comb begin
      unique case (row_step_ff)
         ROW_DOWN: cursor_y_adv = cursor_y_ff + CW'(1);
         ROW_UP:   cursor_y_adv = cursor_y_ff - CW'(1);
         default:  cursor_y_adv = cursor_y_ff;
      endcase
   end

   // control word fetch and handshake
   assign uw         = ucode_rom(upc_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (uw.wait_kind == WAIT_REQ);

   always_comb begin
      unique case (uw.wait_kind)
         WAIT_REQ: go = req_tvalid;
         WAIT_OUT: go = out_free;
         default:  go = 1'b1;
      endcase
   end

   // branch condition
   always_comb begin
      unique case (uw.cond)
         COND_ALWAYS:     cond_true = 1'b1;
         COND_OPC_LOAD:   cond_true = (req_tuser == OPC_LOAD);
         COND_NOT_ACTIVE: cond_true = !line_active_ff;
         COND_AXIS:       cond_true = axis_aligned_ff;
         COND_XMAJ:       cond_true = x_major_ff;
         COND_WALKING:    cond_true = (pixels_left_ff != '0) && !err_ge_gap;
         default:         cond_true = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (!go) begin
         upc_in = upc_ff;
      end else if (cond_true) begin
         upc_in = uw.target;
      end else begin
         upc_in = upc_ff + UPC_W'(1);
      end
   end

   // datapath driven by the control word
   always_comb begin
      sx_in           = sx_ff;
      sy_in           = sy_ff;
      ex_in           = ex_ff;
      ey_in           = ey_ff;
      dx_in           = dx_ff;
      dy_in           = dy_ff;
      line_active_in  = line_active_ff;
      axis_aligned_in = axis_aligned_ff;
      x_major_in      = x_major_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      error_term_in   = error_term_ff;
      span_dx_in      = span_dx_ff;
      span_dy_in      = span_dy_ff;
      row_step_in     = row_step_ff;
      pixels_left_in  = pixels_left_ff;
      gap_in          = gap_ff;
      run_len_in      = run_len_ff;
      hit_in          = hit_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_w_in        = rsp_w_ff;
      rsp_h_in        = rsp_h_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;

      if (go) begin
         unique case (uw.op)
            // capture endpoints and their signed differences
            OP_LATCH: begin
               sx_in = req_sx;
               sy_in = req_sy;
               ex_in = req_ex;
               ey_in = req_ey;
               dx_in = $signed({req_ex[CW-1], req_ex}) - $signed({req_sx[CW-1], req_sx});
               dy_in = $signed({req_ey[CW-1], req_ey}) - $signed({req_sy[CW-1], req_sy});
            end
            // spans, start corner and row direction
            OP_SETUP: begin
               line_active_in  = 1'b1;
               span_dx_in      = dx_ff[CW] ? (CW+1)'(-dx_ff) : (CW+1)'(dx_ff);
               span_dy_in      = dy_ff[CW] ? (CW+1)'(-dy_ff) : (CW+1)'(dy_ff);
               axis_aligned_in = (dx_ff == '0) || (dy_ff == '0);
               if ((dx_ff == '0) || (dy_ff == '0)) begin
                  cursor_x_in = dx_ff[CW] ? ex_ff : sx_ff;
                  cursor_y_in = dy_ff[CW] ? ey_ff : sy_ff;
                  row_step_in = ROW_NONE;
               end else begin
                  cursor_x_in = dx_ff[CW] ? ex_ff : sx_ff;
                  cursor_y_in = dx_ff[CW] ? ey_ff : sy_ff;
                  row_step_in = (dx_ff[CW] == dy_ff[CW]) ? ROW_DOWN : ROW_UP;
               end
            end
            // major axis, error term and walk length
            OP_CLASS: begin
               if (axis_aligned_ff) begin
                  x_major_in     = 1'b0;
                  error_term_in  = '0;
                  pixels_left_in = (CW+1)'(1);
                  gap_in         = '0;
               end else if (span_dx_ff >= span_dy_ff) begin
                  x_major_in     = 1'b1;
                  error_term_in  = span_dx_ff >> 1;
                  pixels_left_in = span_dx_ff;
                  gap_in         = span_dx_ff - span_dy_ff;
               end else begin
                  x_major_in     = 1'b0;
                  error_term_in  = span_dy_ff >> 1;
                  pixels_left_in = span_dy_ff + (CW+1)'(1);
                  gap_in         = span_dy_ff - span_dx_ff;
               end
            end
            // whole rectangle in one result
            OP_AXIS_EMIT: begin
               rsp_valid_in   = 1'b1;
               rsp_x_in       = cursor_x_ff;
               rsp_y_in       = cursor_y_ff;
               rsp_w_in       = span_dx_ff + (CW+1)'(1);
               rsp_h_in       = span_dy_ff + (CW+1)'(1);
               rsp_last_in    = 1'b1;
               line_active_in = 1'b0;
               pixels_left_in = '0;
            end
            OP_XM_INIT: begin
               run_len_in = (CW+1)'(1);
               hit_in     = 1'b0;
            end
            // one pixel of the error walk
            OP_XM_WALK: begin
               if (pixels_left_ff != '0) begin
                  pixels_left_in = pixels_left_ff - (CW+1)'(1);
                  if (err_ge_gap) begin
                     error_term_in = error_term_ff - gap_ff;
                     hit_in        = 1'b1;
                  end else begin
                     error_term_in = error_term_ff + span_dy_ff;
                     run_len_in    = run_len_ff + (CW+1)'(1);
                  end
               end
            end
            // horizontal run, last when the walk ran out
            OP_XM_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = cursor_x_ff;
               rsp_y_in     = cursor_y_ff;
               rsp_w_in     = run_len_ff;
               rsp_h_in     = (CW+1)'(1);
               rsp_last_in  = !hit_ff;
               if (hit_ff) begin
                  cursor_x_in = cursor_x_ff + run_len_ff[CW-1:0];
                  cursor_y_in = cursor_y_adv;
               end else begin
                  line_active_in = 1'b0;
               end
            end
            // single pixel of a steep line
            OP_YM_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = cursor_x_ff;
               rsp_y_in     = cursor_y_ff;
               rsp_w_in     = (CW+1)'(1);
               rsp_h_in     = (CW+1)'(1);
               rsp_last_in  = (pixels_left_ff <= (CW+1)'(1));
               if (pixels_left_ff <= (CW+1)'(1)) begin
                  pixels_left_in = '0;
                  line_active_in = 1'b0;
               end else begin
                  pixels_left_in = pixels_left_ff - (CW+1)'(1);
                  if (err_ge_gap) begin
                     error_term_in = error_term_ff - gap_ff;
                     cursor_x_in   = cursor_x_ff + CW'(1);
                  end else begin
                     error_term_in = error_term_ff + span_dx_ff;
                  end
                  cursor_y_in = cursor_y_adv;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff          <= UA_IDLE;
         rsp_valid_ff    <= 1'b0;
         line_active_ff  <= 1'b0;
         axis_aligned_ff <= 1'b0;
         x_major_ff      <= 1'b0;
      end else begin
         upc_ff          <= upc_in;
         rsp_valid_ff    <= rsp_valid_in;
         line_active_ff  <= line_active_in;
         axis_aligned_ff <= axis_aligned_in;
         x_major_ff      <= x_major_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sx_ff          <= sx_in;
      sy_ff          <= sy_in;
      ex_ff          <= ex_in;
      ey_ff          <= ey_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      cursor_x_ff    <= cursor_x_in;
      cursor_y_ff    <= cursor_y_in;
      error_term_ff  <= error_term_in;
      span_dx_ff     <= span_dx_in;
      span_dy_ff     <= span_dy_in;
      row_step_ff    <= row_step_in;
      pixels_left_ff <= pixels_left_in;
      gap_ff         <= gap_in;
      run_len_ff     <= run_len_in;
      hit_ff         <= hit_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_w_ff       <= rsp_w_in;
      rsp_h_ff       <= rsp_h_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_h_ff, rsp_w_ff, rsp_y_ff, rsp_x_ff};

endmodule

`default_nettype wire

### rtl/core/blsg_checker.sv
`default_nettype none

module blsg_checker #(
   parameter int COORD_WIDTH = 16
) (
   input wire logic                                     clock,
   input wire logic                                     reset,
   input wire logic                                     rsp_tvalid,
   input wire logic                                     rsp_tready,
   input wire logic [((4*COORD_WIDTH+2+7)/8)*8-1:0]     rsp_tdata,
   input wire logic                                     rsp_tlast
);

   localparam int CW = COORD_WIDTH;

   logic [CW:0] run_width;
   logic [CW:0] run_height;

   assign run_width  = rsp_tdata[2*CW +: CW+1];
   assign run_height = rsp_tdata[3*CW+1 +: CW+1];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // nothing comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // runs always cover at least one pixel
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (run_width != '0) && (run_height != '0))
      else $error("empty run");

   // only the rectangle spans several rows, and it completes the line
   a_tall_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (run_height != (CW+1)'(1)) |-> rsp_tlast)
      else $error("multi-row run not last");

endmodule

bind bresenham_line_span_generator blsg_checker #(.COORD_WIDTH(COORD_WIDTH)) u_blsg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
